// ===== design/jfp_pkg.sv =====
// ----------------------------------------------------------------------------
// jfp_pkg
// Shared types and codes for the start/end framed joystick command parser.
// ----------------------------------------------------------------------------
package jfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int AXIS_W  = 10;
    localparam int REPORT_W = 11;
    localparam int BUTTON_W = 9;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int OUT_DATA_W = 40;

    // Input operation codes
    typedef enum logic [OP_W-1:0] {
        OP_BYTE        = 2'd0,
        OP_READ_AXES   = 2'd1,
        OP_READ_BUTTON = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BYTE  = 3'd0,
        REG_END_BYTE    = 3'd1,
        REG_AXIS_OFFSET = 3'd2,
        REG_VALID_LOW   = 3'd3,
        REG_VALID_HIGH  = 3'd4
    } reg_idx_t;

    // Last accepted frame type as reported
    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_BUTTON   = 2'd1,
        KIND_JOYSTICK = 2'd2
    } kind_t;

    // Command handed from the classifier to the state update
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_BUTTON,
        CMD_JOYSTICK,
        CMD_READ_AXES,
        CMD_READ_BUTTON
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BYTE_W-1:0]  button;
        logic [AXIS_W-1:0]  x_value;
        logic [AXIS_W-1:0]  y_value;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [AXIS_W-1:0] axis_offset;
        logic [AXIS_W-1:0] valid_low;
        logic [AXIS_W-1:0] valid_high;
    } cfg_t;

endpackage

// ===== design/jfp_front.sv =====
// ----------------------------------------------------------------------------
// jfp_front
// Frame tracker: hunts for the start byte, collects payload and turns each
// input beat into one command for the state update.
// ----------------------------------------------------------------------------
module jfp_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  jfp_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_op,
    input  logic [7:0]            in_byte,
    output logic                  push_valid,
    input  logic                  push_ready,
    output jfp_pkg::cmd_t         push_data
);
    import jfp_pkg::*;

    localparam logic [2:0] FIRST_POS  = 3'd1;
    localparam logic [2:0] BUTTON_POS = 3'd2;
    localparam logic [2:0] LAST_POS   = 3'd7;
    localparam int         PAYLOAD_N  = 6;

    logic              in_frame_reg, in_frame_next;
    logic [2:0]        pos_reg, pos_next;
    logic [BYTE_W-1:0] payload_reg [PAYLOAD_N];
    logic              wr_en;
    logic              accept;
    logic [AXIS_W-1:0] x_sum, y_sum;

    // ASCII digit, saturated to 0..9
    function automatic logic [3:0] digit_of(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        d = b - 8'd48;
        if (b < 8'd48) begin
            return 4'd0;
        end else if (b > 8'd57) begin
            return 4'd9;
        end
        return d[3:0];
    endfunction

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid & push_ready;

    assign x_sum = AXIS_W'(digit_of(payload_reg[0])) * 10'd100
                 + AXIS_W'(digit_of(payload_reg[1])) * 10'd10
                 + AXIS_W'(digit_of(payload_reg[2]));
    assign y_sum = AXIS_W'(digit_of(payload_reg[3])) * 10'd100
                 + AXIS_W'(digit_of(payload_reg[4])) * 10'd10
                 + AXIS_W'(digit_of(payload_reg[5]));

    always_comb begin
        in_frame_next     = in_frame_reg;
        pos_next          = pos_reg;
        wr_en             = 1'b0;
        push_data.kind    = CMD_NONE;
        push_data.button  = payload_reg[0];
        push_data.x_value = x_sum;
        push_data.y_value = y_sum;
        unique case (op_t'(in_op))
            OP_BYTE: begin
                priority if (!in_frame_reg) begin
                    if (in_byte == cfg.start_byte) begin
                        in_frame_next = 1'b1;
                        pos_next      = FIRST_POS;
                    end
                end else if (in_byte == cfg.end_byte) begin
                    // end byte closes the frame whatever its length
                    if (pos_reg == BUTTON_POS) begin
                        push_data.kind = CMD_BUTTON;
                    end else if (pos_reg == LAST_POS) begin
                        push_data.kind = CMD_JOYSTICK;
                    end
                    in_frame_next = 1'b0;
                    pos_next      = 3'd0;
                end else if (pos_reg != LAST_POS) begin
                    wr_en    = 1'b1;
                    pos_next = pos_reg + 3'd1;
                end else begin
                    // frame too long: drop
                    in_frame_next = 1'b0;
                    pos_next      = 3'd0;
                end
            end
            OP_READ_AXES:   push_data.kind = CMD_READ_AXES;
            OP_READ_BUTTON: push_data.kind = CMD_READ_BUTTON;
            default:        push_data.kind = CMD_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            pos_reg      <= 3'd0;
        end else if (accept) begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
        end
    end

    for (genvar i = 0; i < PAYLOAD_N; i++) begin : g_payload
        always_ff @(posedge aclk) begin
            if (accept && wr_en && pos_reg == 3'(i + 1)) begin
                payload_reg[i] <= in_byte;
            end
        end
    end

endmodule

// ===== design/jfp_queue.sv =====
// ----------------------------------------------------------------------------
// jfp_queue
// Small command queue between the frame tracker and the state update.
// ----------------------------------------------------------------------------
module jfp_queue #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  jfp_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output jfp_pkg::cmd_t pop_data
);
    import jfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/jfp_back.sv =====
// ----------------------------------------------------------------------------
// jfp_back
// Command state update and result register: applies one command per beat
// and builds the status report from the updated state.
// ----------------------------------------------------------------------------
module jfp_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  jfp_pkg::cfg_t                      cfg,
    input  logic                               pop_valid,
    output logic                               pop_ready,
    input  jfp_pkg::cmd_t                      pop_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [jfp_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import jfp_pkg::*;

    kind_t               kind_reg, kind_next;
    logic [AXIS_W-1:0]   x_reg, x_next;
    logic [AXIS_W-1:0]   y_reg, y_next;
    logic [BUTTON_W-1:0] button_reg, button_next;
    logic                pending_reg, pending_next;
    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [REPORT_W-1:0] x_report, y_report;
    logic                in_range;
    logic                do_pop;

    assign pop_ready = !out_valid_reg || m_tready;
    assign do_pop    = pop_valid && pop_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb begin
        kind_next    = kind_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        button_next  = button_reg;
        pending_next = pending_reg;
        unique case (pop_data.kind)
            CMD_BUTTON: begin
                button_next  = {1'b0, pop_data.button};
                pending_next = 1'b1;
                kind_next    = KIND_BUTTON;
            end
            CMD_JOYSTICK: begin
                kind_next = KIND_JOYSTICK;
                // only a change of either axis counts as a new command
                if (pop_data.x_value != x_reg || pop_data.y_value != y_reg) begin
                    pending_next = 1'b1;
                    x_next       = pop_data.x_value;
                    y_next       = pop_data.y_value;
                end
            end
            CMD_READ_AXES: begin
                if (kind_reg == KIND_JOYSTICK) begin
                    pending_next = 1'b0;
                end
            end
            CMD_READ_BUTTON: begin
                if (kind_reg == KIND_BUTTON) begin
                    pending_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign x_report = {1'b0, x_next} - {1'b0, cfg.axis_offset};
    assign y_report = {1'b0, y_next} - {1'b0, cfg.axis_offset};
    assign in_range = x_next >= cfg.valid_low && x_next <= cfg.valid_high
                   && y_next >= cfg.valid_low && y_next <= cfg.valid_high
                   && kind_next != KIND_NONE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg      <= KIND_NONE;
            x_reg         <= '0;
            y_reg         <= '0;
            button_reg    <= '1;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (do_pop) begin
                kind_reg    <= kind_next;
                x_reg       <= x_next;
                y_reg       <= y_next;
                button_reg  <= button_next;
                pending_reg <= pending_next;
            end
            if (do_pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop) begin
            out_data_reg <= {5'd0, in_range, button_next, y_report, x_report,
                             pending_next, kind_next};
        end
    end

endmodule

// ===== design/stx_etx_joystick_frame_parser.sv =====
// ----------------------------------------------------------------------------
// stx_etx_joystick_frame_parser
// Start/end framed button and joystick command parser with status report.
// ----------------------------------------------------------------------------
// Each input beat is either a received serial byte or a read request, and
// each one yields exactly one status beat on the master side. The block
// takes one beat per clock while the queue has room: the frame tracker
// classifies a beat in the cycle it is accepted, a command queue (two
// entries by default) holds it, and the state update pops it, applies it
// and loads the result register that drives m_tvalid. Sustained rate is
// one beat per cycle while m_tready holds, set by the state update loop;
// the queue and the result register let either side stall without losing
// a beat. Frames are start, one button byte, end; or start, six ASCII
// digits (X then Y), end. An end byte anywhere else, or a seventh data
// byte, drops the frame.
// Configuration registers may be written only while no beat is in flight.
// ----------------------------------------------------------------------------
module stx_etx_joystick_frame_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    // status beats
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] last_type, [2] new_command, [13:3] x_axis, [24:14] y_axis,
    // [33:25] button, [34] joystick_valid, [39:35] zero
    output logic [jfp_pkg::OUT_DATA_W-1:0] m_tdata,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [jfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jfp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import jfp_pkg::*;

    cfg_t cfg_reg;
    logic push_valid, push_ready;
    cmd_t push_data;
    logic pop_valid, pop_ready;
    cmd_t pop_data;

    // Always take configuration writes; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte  <= 8'd2;
            cfg_reg.end_byte    <= 8'd3;
            cfg_reg.axis_offset <= 10'd200;
            cfg_reg.valid_low   <= 10'd100;
            cfg_reg.valid_high  <= 10'd300;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_START_BYTE:  cfg_reg.start_byte  <= cfg_data[7:0];
                REG_END_BYTE:    cfg_reg.end_byte    <= cfg_data[7:0];
                REG_AXIS_OFFSET: cfg_reg.axis_offset <= cfg_data;
                REG_VALID_LOW:   cfg_reg.valid_low   <= cfg_data;
                REG_VALID_HIGH:  cfg_reg.valid_high  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Classify each beat and track frame position.
    jfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_byte    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Hold commands while the result side stalls.
    jfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Apply commands and register the status report.
    jfp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
